[hdl/rvd_pkg.sv]
package rvd_pkg;

    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 120;
    localparam int OUT_USED_W  = 115;

    localparam logic [4:0] OPC_LOAD   = 5'd0;
    localparam logic [4:0] OPC_OPIMM  = 5'd4;
    localparam logic [4:0] OPC_AUIPC  = 5'd5;
    localparam logic [4:0] OPC_STORE  = 5'd8;
    localparam logic [4:0] OPC_OP     = 5'd12;
    localparam logic [4:0] OPC_LUI    = 5'd13;
    localparam logic [4:0] OPC_BRANCH = 5'd24;
    localparam logic [4:0] OPC_JALR   = 5'd25;
    localparam logic [4:0] OPC_JAL    = 5'd27;
    localparam logic [4:0] OPC_SYSTEM = 5'd28;

    // Major opcodes ending in 111 announce encodings longer than 32 bits.
    localparam logic [2:0] OPC_LONG_TAIL = 3'b111;

    localparam logic [31:0] RET_WORD = 32'h0000_8067;

    localparam logic [2:0] FMT_UNDEF = 3'd0;
    localparam logic [2:0] FMT_R     = 3'd1;
    localparam logic [2:0] FMT_I     = 3'd2;
    localparam logic [2:0] FMT_S     = 3'd3;
    localparam logic [2:0] FMT_B     = 3'd4;
    localparam logic [2:0] FMT_U     = 3'd5;
    localparam logic [2:0] FMT_J     = 3'd6;
    localparam logic [2:0] FMT_OTHER = 3'd7;

    typedef struct packed {
        logic        fetch_valid;
        logic [15:0] fetch_pc;
        logic [31:0] instruction_word;
        logic        issue_full;
    } fetch_item_t;

    typedef struct packed {
        logic issue;
        logic stage_full;
    } hold_ctrl_t;

    typedef struct packed {
        logic        issue_valid;
        logic        fetch_target_valid;
        logic        stage_full;
        logic [15:0] out_pc;
        logic [4:0]  dest_reg;
        logic [9:0]  source_regs;
        logic [9:0]  function_code;
        logic [4:0]  major_opcode;
        logic signed [31:0] immediate;
        logic [2:0]  format_code;
        logic [14:0] decode_flags;
        logic [15:0] fetch_target;
    } decode_result_t;

endpackage

[hdl/rv32i_decode_stage.sv]
// RV32I decode stage.
// Slave channel: one word per fetch cycle, carrying fetch_valid, fetch_pc, the
// instruction word and the issue stage's full flag. Master channel: one decoded
// word per accepted input word, with the register fields, function codes,
// opcode, sign-extended immediate, format, class flags and next fetch address.
// A single hold register keeps an instruction while issue reports full; an
// offer that arrives while it is occupied is dropped.
// Each word passes an input register and then a result register before it is
// presented on the master channel. While the receiver accepts results, one word
// is taken every cycle; the limit is the single decode pass between the two
// registers.
// Reset empties the hold register and both pipeline registers.
// When the receiver stalls, the result register holds its word, the input
// register fills behind it and s_tready falls; no word is lost or repeated.
module rv32i_decode_stage #(
    parameter int CODE_ADDRESS_WIDTH = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fetch_valid, fetch_pc, instruction_word, issue_full, zero padding
    input  logic [rvd_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // issue_valid, fetch_target_valid, stage_full, out_pc, dest_reg, source_regs,
    // function_code, major_opcode, immediate, format_code, decode_flags,
    // fetch_target, zero padding
    output logic [rvd_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    logic                   in_valid_reg;
    logic                   in_valid_next;
    rvd_pkg::fetch_item_t   in_item_reg;
    rvd_pkg::fetch_item_t   in_item_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    rvd_pkg::decode_result_t out_result_reg;
    rvd_pkg::decode_result_t out_result_next;
    logic                   advance;
    logic                   take;
    rvd_pkg::hold_ctrl_t    ctrl;
    logic [CODE_ADDRESS_WIDTH-1:0] dec_pc;
    logic [31:0]            dec_word;
    rvd_pkg::decode_result_t dec_result;

    assign advance  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;
    assign take     = s_tvalid & s_tready;

    always_comb
    begin
        in_item_next = in_item_reg;
        if (take)
        begin
            in_item_next.fetch_valid      = s_tdata[0];
            in_item_next.fetch_pc         = s_tdata[16:1];
            in_item_next.instruction_word = s_tdata[48:17];
            in_item_next.issue_full       = s_tdata[49];
        end
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_comb
    begin
        out_result_next = out_result_reg;
        if (advance)
            out_result_next = dec_result;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg    <= in_item_next;
        out_result_reg <= out_result_next;
    end

    rvd_hold #(
        .CAW (CODE_ADDRESS_WIDTH)
    ) u_hold (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .ctrl    (ctrl),
        .pc      (dec_pc),
        .word    (dec_word)
    );

    rvd_decoder #(
        .CAW (CODE_ADDRESS_WIDTH)
    ) u_decoder (
        .ctrl   (ctrl),
        .pc     (dec_pc),
        .word   (dec_word),
        .result (dec_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(rvd_pkg::OUT_TDATA_W - rvd_pkg::OUT_USED_W){1'b0}},
                       out_result_reg.fetch_target,
                       out_result_reg.decode_flags,
                       out_result_reg.format_code,
                       out_result_reg.immediate,
                       out_result_reg.major_opcode,
                       out_result_reg.function_code,
                       out_result_reg.source_regs,
                       out_result_reg.dest_reg,
                       out_result_reg.out_pc,
                       out_result_reg.stage_full,
                       out_result_reg.fetch_target_valid,
                       out_result_reg.issue_valid};

endmodule

[hdl/rvd_hold.sv]
module rvd_hold #(
    parameter int CAW = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  rvd_pkg::fetch_item_t item,
    output rvd_pkg::hold_ctrl_t ctrl,
    output logic [CAW-1:0]      pc,
    output logic [31:0]         word
);

    logic           hold_full_reg;
    logic           hold_full_next;
    logic [CAW-1:0] held_pc_reg;
    logic [CAW-1:0] held_pc_next;
    logic [31:0]    held_word_reg;
    logic [31:0]    held_word_next;
    logic           avail;
    logic           save;

    assign avail = item.fetch_valid | hold_full_reg;
    assign save  = item.fetch_valid & ~hold_full_reg;

    // A new offer only lands in the hold register when it is empty; otherwise it is dropped.
    always_comb
    begin
        held_pc_next   = held_pc_reg;
        held_word_next = held_word_reg;
        hold_full_next = hold_full_reg;
        if (advance)
        begin
            if (save)
            begin
                held_pc_next   = CAW'(item.fetch_pc);
                held_word_next = item.instruction_word;
            end
            hold_full_next = avail & item.issue_full;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_full_reg <= 1'b0;
        end
        else
        begin
            hold_full_reg <= hold_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_pc_reg   <= held_pc_next;
        held_word_reg <= held_word_next;
    end

    assign ctrl.issue      = avail & ~item.issue_full;
    assign ctrl.stage_full = avail & item.issue_full;
    assign pc   = hold_full_reg ? held_pc_reg : CAW'(item.fetch_pc);
    assign word = hold_full_reg ? held_word_reg : item.instruction_word;

endmodule

[hdl/rvd_decoder.sv]
module rvd_decoder #(
    parameter int CAW = 16
) (
    input  rvd_pkg::hold_ctrl_t     ctrl,
    input  logic [CAW-1:0]          pc,
    input  logic [31:0]             word,
    output rvd_pkg::decode_result_t result
);

    logic [4:0]  op;
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [2:0]  fmt;
    logic [31:0] imm;
    logic        is_load;
    logic        op_store;
    logic        op_branch;
    logic        is_jal;
    logic        is_jalr;
    logic        is_lui;
    logic        is_auipc;
    logic        is_opimm;
    logic        op_system;
    logic        is_ret;
    logic        nodest;
    logic        rs1reg;
    logic        rs2reg;
    logic [CAW-1:0] target;

    assign op  = word[6:2];
    assign rd  = word[11:7];
    assign rs1 = word[19:15];
    assign rs2 = word[24:20];

    always_comb
    begin
        case (op)
            rvd_pkg::OPC_LOAD, rvd_pkg::OPC_OPIMM,
            rvd_pkg::OPC_JALR, rvd_pkg::OPC_SYSTEM: fmt = rvd_pkg::FMT_I;
            rvd_pkg::OPC_STORE:                     fmt = rvd_pkg::FMT_S;
            rvd_pkg::OPC_OP:                        fmt = rvd_pkg::FMT_R;
            rvd_pkg::OPC_AUIPC, rvd_pkg::OPC_LUI:   fmt = rvd_pkg::FMT_U;
            rvd_pkg::OPC_BRANCH:                    fmt = rvd_pkg::FMT_B;
            rvd_pkg::OPC_JAL:                       fmt = rvd_pkg::FMT_J;
            default:
            begin
                if (op[2:0] == rvd_pkg::OPC_LONG_TAIL)
                    fmt = rvd_pkg::FMT_UNDEF;
                else
                    fmt = rvd_pkg::FMT_OTHER;
            end
        endcase
    end

    always_comb
    begin
        case (fmt)
            rvd_pkg::FMT_I: imm = {{20{word[31]}}, word[31:20]};
            rvd_pkg::FMT_S: imm = {{20{word[31]}}, word[31:25], word[11:7]};
            rvd_pkg::FMT_B: imm = {{20{word[31]}}, word[7], word[30:25], word[11:8], 1'b0};
            rvd_pkg::FMT_U: imm = {word[31:12], 12'h000};
            rvd_pkg::FMT_J: imm = {{12{word[31]}}, word[19:12], word[20], word[30:21], 1'b0};
            default:        imm = 32'h0000_0000;
        endcase
    end

    assign is_load   = (op == rvd_pkg::OPC_LOAD);
    assign op_store  = (op == rvd_pkg::OPC_STORE);
    assign op_branch = (op == rvd_pkg::OPC_BRANCH);
    assign is_jal    = (op == rvd_pkg::OPC_JAL);
    assign is_jalr   = (op == rvd_pkg::OPC_JALR);
    assign is_lui    = (op == rvd_pkg::OPC_LUI);
    assign is_auipc  = (op == rvd_pkg::OPC_AUIPC);
    assign is_opimm  = (op == rvd_pkg::OPC_OPIMM);
    assign op_system = (op == rvd_pkg::OPC_SYSTEM);
    assign is_ret    = (word == rvd_pkg::RET_WORD);
    assign nodest    = op_branch | op_store | (rd == 5'd0);
    assign rs1reg    = ~is_jal & ~is_lui & ~is_auipc & (rs1 != 5'd0);
    assign rs2reg    = ~is_opimm & ~is_load & ~is_jal & ~is_jalr & ~is_lui & ~is_auipc &
                       (rs2 != 5'd0);

    // Address arithmetic wraps at the code address width.
    assign target = pc + (is_jal ? CAW'(imm) : CAW'(4));

    // Nothing issued leaves every field but the occupancy flag at zero.
    always_comb
    begin
        result = '0;
        result.stage_full = ctrl.stage_full;
        if (ctrl.issue)
        begin
            result.issue_valid        = 1'b1;
            result.fetch_target_valid = ~(op_branch | is_jalr);
            result.out_pc             = 16'(pc);
            result.dest_reg           = nodest ? 5'd0 : rd;
            result.source_regs        = {rs2, rs1};
            result.function_code      = {word[31:25], word[14:12]};
            result.major_opcode       = op;
            result.immediate          = imm;
            result.format_code        = fmt;
            result.decode_flags       = {fmt == rvd_pkg::FMT_R, nodest,
                                         op_branch | is_jal | is_jalr, is_jal | is_jalr,
                                         op_system, is_opimm, is_lui, is_ret, is_jalr,
                                         is_jal, op_branch, op_store, is_load, rs2reg, rs1reg};
            result.fetch_target       = 16'(target);
        end
    end

endmodule

[hdl/rvd_checker.sv]
module rvd_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [119:0] m_tdata
);

    // A stalled result word must stay put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A word that issues nothing carries only the occupancy flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> m_tdata[119:3] == 117'd0 && !m_tdata[1])
        else $error("fields set on a word that issues nothing");

    // An instruction cannot go to issue and stay in the hold register at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && m_tdata[2]))
        else $error("issued and still held");

    // Instructions without a destination report register zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[97] |-> m_tdata[23:19] == 5'd0)
        else $error("destination given for an instruction that writes none");

    // The input side is ready whenever the result side is empty now and was empty in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$past(m_tvalid) && !m_tvalid |-> s_tready)
        else $error("input stalled with an empty pipeline");

endmodule

bind rv32i_decode_stage rvd_checker u_rvd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
